### rtl/core/vtmd_pkg.sv
// ---------------------------------------------------------------------------
// Vibration transmission mode decider: shared package
// Widths, timing constants, reason codes and register indexes.
// ---------------------------------------------------------------------------
package vtmd_pkg;

  localparam int unsigned MISSING_INTERVAL_MS = 60000;
  localparam int unsigned US_PER_MS           = 1000;
  localparam logic [63:0] WINDOW_US           = 64'd640000;
  localparam logic [63:0] MISSING_INTERVAL_US =
    64'(MISSING_INTERVAL_MS) * 64'(US_PER_MS);

  localparam int unsigned VOTE_DEPTH = 3;
  localparam int unsigned VOTE_NEED  = 2;
  localparam int unsigned VOTE_CNT_W = $clog2(VOTE_DEPTH + 1);

  localparam int unsigned BOOT_W     = 32;
  localparam int unsigned IDX_W      = 32;
  localparam int unsigned TS_W       = 64;
  localparam int unsigned G_W        = 16;   // Q5.11 g
  localparam int unsigned SQ_W       = 2 * G_W;
  localparam int unsigned SUM_W      = SQ_W + 2;
  localparam int unsigned REC_MS_W   = 20;
  localparam int unsigned REC_US_W   = 30;   // 2^20 * 1000 < 2^30
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned REASON_W   = 3;

  typedef enum logic [REASON_W-1:0] {
    REASON_NONE          = 3'd0,
    REASON_RMS_LOW       = 3'd1,
    REASON_RMS_HIGH      = 3'd2,
    REASON_SEVERE        = 3'd3,
    REASON_QUALITY       = 3'd4,
    REASON_BASELINE_MISS = 3'd5,
    REASON_STORAGE       = 3'd6,
    REASON_RECOVERY_HOLD = 3'd7
  } reason_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASELINE    = 3'd0,
    CFG_RECOVERY_MS = 3'd1,
    CFG_RMS_LOW     = 3'd2,
    CFG_RMS_HIGH    = 3'd3,
    CFG_SEVERE_LOW  = 3'd4,
    CFG_SEVERE_HIGH = 3'd5,
    CFG_SEVERE_PEAK = 3'd6
  } cfg_reg_t;

  function automatic logic [SQ_W-1:0] sq_g(input logic [G_W-1:0] v);
    return SQ_W'(v) * SQ_W'(v);
  endfunction

endpackage

### rtl/core/vtmd_ifs.sv
// ---------------------------------------------------------------------------
// Vibration transmission mode decider: channel interfaces
// Window input, decision output and register write channels.
// ---------------------------------------------------------------------------
interface vtmd_in_if;
  logic                        valid;
  logic                        ready;
  logic [vtmd_pkg::BOOT_W-1:0] boot_ident;
  logic [vtmd_pkg::IDX_W-1:0]  window_index;
  logic [vtmd_pkg::TS_W-1:0]   timestamp_us;
  logic                        quality_ok;
  logic [vtmd_pkg::G_W-1:0]    rms_x;
  logic [vtmd_pkg::G_W-1:0]    rms_y;
  logic [vtmd_pkg::G_W-1:0]    rms_z;
  logic [vtmd_pkg::G_W-1:0]    peak_x;
  logic [vtmd_pkg::G_W-1:0]    peak_y;
  logic [vtmd_pkg::G_W-1:0]    peak_z;
  logic                        storage_full;

  modport source (output valid, boot_ident, window_index, timestamp_us, quality_ok,
                  rms_x, rms_y, rms_z, peak_x, peak_y, peak_z, storage_full,
                  input ready);
  modport sink   (input valid, boot_ident, window_index, timestamp_us, quality_ok,
                  rms_x, rms_y, rms_z, peak_x, peak_y, peak_z, storage_full,
                  output ready);
endinterface

interface vtmd_out_if;
  logic                          valid;
  logic                          ready;
  logic                          priority_mode;
  logic [vtmd_pkg::REASON_W-1:0] reason_code;

  modport source (output valid, priority_mode, reason_code, input ready);
  modport sink   (input valid, priority_mode, reason_code, output ready);
endinterface

interface vtmd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [vtmd_pkg::CFG_IDX_W-1:0]  index;
  logic [vtmd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/vibration_transmission_mode_decider_top.sv
// ---------------------------------------------------------------------------
// Vibration transmission mode decider
// Picks priority or periodic transmission, with a reason, per feature window.
// ---------------------------------------------------------------------------
// Takes one word (one 640 ms feature window) per clock while the output
// is not stalled and returns one decision word for each, passed from the
// input register to the result register. Rate is one word per cycle
// unless the output stalls: the axis squares and peak max are formed on
// the way into the input register, and the decision stage reads and
// updates all history (continuity, votes, recovery, missing-baseline
// timer) as the word enters the result register, so the next window
// already sees it. in_ch.ready only drops when both registers are full
// and the result is not taken. Register writes are always accepted; the
// four band thresholds are squared at write time; no clearing after reset.
module vibration_transmission_mode_decider_top (
  input  logic        clk,
  input  logic        rst_n,
  vtmd_in_if.sink     in_ch,
  vtmd_out_if.source  out_ch,
  vtmd_cfg_if.sink    cfg_ch
);

  // Window as held in the input register
  typedef struct packed {
    logic [vtmd_pkg::BOOT_W-1:0]  boot;
    logic [vtmd_pkg::IDX_W-1:0]   idx;
    logic [vtmd_pkg::TS_W-1:0]    ts;
    logic                         qok;
    logic                         full;
    logic [vtmd_pkg::SUM_W-1:0]   sum;   // rx^2 + ry^2 + rz^2
    logic [vtmd_pkg::G_W-1:0]     peak;  // largest axis peak
  } win_t;

  // -------------------------------------------------------------------------
  // Handshake
  // -------------------------------------------------------------------------
  logic  s1_valid_r;
  win_t  s1_r;
  logic  out_valid_r;
  logic  prio_r;
  vtmd_pkg::reason_t reason_r;

  logic  advance;   // decision stage may hand a word to the result register
  logic  s2_fire;
  logic  in_fire;

  assign advance = !out_valid_r || out_ch.ready;
  assign s2_fire = s1_valid_r && advance;
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_fire = in_ch.valid && in_ch.ready;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.priority_mode = prio_r;
  assign out_ch.reason_code   = reason_r;
  assign cfg_ch.ready         = 1'b1;

  // -------------------------------------------------------------------------
  // Configuration registers
  // -------------------------------------------------------------------------
  logic                            base_cfg_r;
  logic [vtmd_pkg::REC_MS_W-1:0]   rec_ms_r;
  logic [vtmd_pkg::REC_US_W-1:0]   rec_us_r;
  logic [vtmd_pkg::G_W-1:0]        rms_lo_r, rms_hi_r, sev_lo_r, sev_hi_r, sev_peak_r;
  logic [vtmd_pkg::SQ_W-1:0]       sq_rms_lo_r, sq_rms_hi_r, sq_sev_lo_r, sq_sev_hi_r;
  logic [vtmd_pkg::SQ_W-1:0]       cfg_sq;
  logic                            cfg_ok;

  assign cfg_sq = vtmd_pkg::sq_g(cfg_ch.data[vtmd_pkg::G_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_cfg_r  <= 1'b0;
      rec_ms_r    <= '0;
      rec_us_r    <= '0;
      rms_lo_r    <= '0;
      rms_hi_r    <= '0;
      sev_lo_r    <= '0;
      sev_hi_r    <= '0;
      sev_peak_r  <= '0;
      sq_rms_lo_r <= '0;
      sq_rms_hi_r <= '0;
      sq_sev_lo_r <= '0;
      sq_sev_hi_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (vtmd_pkg::cfg_reg_t'(cfg_ch.index))
        vtmd_pkg::CFG_BASELINE: begin
          base_cfg_r <= cfg_ch.data[0];
        end
        vtmd_pkg::CFG_RECOVERY_MS: begin
          rec_ms_r <= cfg_ch.data[vtmd_pkg::REC_MS_W-1:0];
          rec_us_r <= vtmd_pkg::REC_US_W'(cfg_ch.data[vtmd_pkg::REC_MS_W-1:0])
                      * vtmd_pkg::REC_US_W'(vtmd_pkg::US_PER_MS);
        end
        vtmd_pkg::CFG_RMS_LOW: begin
          rms_lo_r    <= cfg_ch.data[vtmd_pkg::G_W-1:0];
          sq_rms_lo_r <= cfg_sq;
        end
        vtmd_pkg::CFG_RMS_HIGH: begin
          rms_hi_r    <= cfg_ch.data[vtmd_pkg::G_W-1:0];
          sq_rms_hi_r <= cfg_sq;
        end
        vtmd_pkg::CFG_SEVERE_LOW: begin
          sev_lo_r    <= cfg_ch.data[vtmd_pkg::G_W-1:0];
          sq_sev_lo_r <= cfg_sq;
        end
        vtmd_pkg::CFG_SEVERE_HIGH: begin
          sev_hi_r    <= cfg_ch.data[vtmd_pkg::G_W-1:0];
          sq_sev_hi_r <= cfg_sq;
        end
        vtmd_pkg::CFG_SEVERE_PEAK: begin
          sev_peak_r <= cfg_ch.data[vtmd_pkg::G_W-1:0];
        end
        default: begin
          // index beyond the register list: dropped
        end
      endcase
    end
  end

  // Baseline needs a hold time, strictly ordered thresholds, nonzero peak
  assign cfg_ok = base_cfg_r && (rec_ms_r != '0) &&
                  (sev_lo_r < rms_lo_r) && (rms_lo_r < rms_hi_r) &&
                  (rms_hi_r < sev_hi_r) && (sev_peak_r != '0);

  // -------------------------------------------------------------------------
  // Input stage: squares and peak max on the way into the input register
  // -------------------------------------------------------------------------
  win_t                     s1_nxt;
  logic [vtmd_pkg::G_W-1:0] peak_xy;

  always_comb begin
    peak_xy     = (in_ch.peak_x > in_ch.peak_y) ? in_ch.peak_x : in_ch.peak_y;
    s1_nxt.boot = in_ch.boot_ident;
    s1_nxt.idx  = in_ch.window_index;
    s1_nxt.ts   = in_ch.timestamp_us;
    s1_nxt.qok  = in_ch.quality_ok;
    s1_nxt.full = in_ch.storage_full;
    s1_nxt.sum  = vtmd_pkg::SUM_W'(vtmd_pkg::sq_g(in_ch.rms_x))
                + vtmd_pkg::SUM_W'(vtmd_pkg::sq_g(in_ch.rms_y))
                + vtmd_pkg::SUM_W'(vtmd_pkg::sq_g(in_ch.rms_z));
    s1_nxt.peak = (in_ch.peak_z > peak_xy) ? in_ch.peak_z : peak_xy;
  end

  // -------------------------------------------------------------------------
  // Decision stage state
  // -------------------------------------------------------------------------
  logic                              hist_valid_r, hist_valid_nxt;
  logic [vtmd_pkg::BOOT_W-1:0]       last_boot_r, last_boot_nxt;
  logic [vtmd_pkg::IDX_W-1:0]        last_idx_r, last_idx_nxt;
  logic [vtmd_pkg::TS_W-1:0]         last_ts_r, last_ts_nxt;
  logic [vtmd_pkg::VOTE_DEPTH-1:0]   low_votes_r, low_votes_nxt;
  logic [vtmd_pkg::VOTE_DEPTH-1:0]   high_votes_r, high_votes_nxt;
  logic [vtmd_pkg::VOTE_CNT_W-1:0]   vote_cnt_r, vote_cnt_nxt;
  logic                              in_rec_r, in_rec_nxt;
  logic [vtmd_pkg::TS_W-1:0]         rec_start_r, rec_start_nxt;
  logic                              miss_rep_r, miss_rep_nxt;
  logic [vtmd_pkg::TS_W-1:0]         miss_time_r, miss_time_nxt;
  logic                              prio_nxt;
  vtmd_pkg::reason_t                 reason_nxt;

  // state after a continuity break has been applied
  logic                              brk;
  logic [vtmd_pkg::VOTE_DEPTH-1:0]   e_low, e_high;
  logic [vtmd_pkg::VOTE_CNT_W-1:0]   e_cnt;
  logic                              e_rec, e_miss_rep;
  logic [vtmd_pkg::TS_W-1:0]         e_miss_time;

  logic                              sev, lo, hi, eligible, held;
  logic [vtmd_pkg::VOTE_DEPTH-1:0]   low_add, high_add;
  logic [vtmd_pkg::VOTE_CNT_W-1:0]   cnt_add, low_hits, high_hits;

  always_comb begin
    brk = hist_valid_r &&
          ((s1_r.boot != last_boot_r) ||
           (s1_r.idx != last_idx_r + vtmd_pkg::IDX_W'(1)) ||
           (s1_r.ts != last_ts_r + vtmd_pkg::WINDOW_US));

    e_low       = brk ? '0 : low_votes_r;
    e_high      = brk ? '0 : high_votes_r;
    e_cnt       = brk ? '0 : vote_cnt_r;
    e_rec       = !brk && in_rec_r;
    e_miss_rep  = !brk && miss_rep_r;
    e_miss_time = brk ? '0 : miss_time_r;

    // squared-domain compares
    sev = (s1_r.sum <= vtmd_pkg::SUM_W'(sq_sev_lo_r)) ||
          (s1_r.sum >= vtmd_pkg::SUM_W'(sq_sev_hi_r)) ||
          (s1_r.peak >= sev_peak_r);
    lo  = (s1_r.sum <= vtmd_pkg::SUM_W'(sq_rms_lo_r));
    hi  = (s1_r.sum >= vtmd_pkg::SUM_W'(sq_rms_hi_r));

    // vote window: fill, then slide (oldest at bit 0)
    low_add  = e_low;
    high_add = e_high;
    cnt_add  = e_cnt;
    if (e_cnt < vtmd_pkg::VOTE_CNT_W'(vtmd_pkg::VOTE_DEPTH)) begin
      low_add[e_cnt[$clog2(vtmd_pkg::VOTE_DEPTH)-1:0]]  = lo;
      high_add[e_cnt[$clog2(vtmd_pkg::VOTE_DEPTH)-1:0]] = hi;
      cnt_add = e_cnt + vtmd_pkg::VOTE_CNT_W'(1);
    end else begin
      low_add  = {lo, e_low[vtmd_pkg::VOTE_DEPTH-1:1]};
      high_add = {hi, e_high[vtmd_pkg::VOTE_DEPTH-1:1]};
    end
    low_hits  = '0;
    high_hits = '0;
    for (int i = 0; i < vtmd_pkg::VOTE_DEPTH; i++) begin
      low_hits  = low_hits + vtmd_pkg::VOTE_CNT_W'(low_add[i]);
      high_hits = high_hits + vtmd_pkg::VOTE_CNT_W'(high_add[i]);
    end

    eligible = !e_miss_rep ||
               (s1_r.ts - e_miss_time >= vtmd_pkg::MISSING_INTERVAL_US);
    held     = e_rec &&
               (s1_r.ts - rec_start_r < vtmd_pkg::TS_W'(rec_us_r));

    hist_valid_nxt = hist_valid_r && !brk;
    last_boot_nxt  = last_boot_r;
    last_idx_nxt   = last_idx_r;
    last_ts_nxt    = last_ts_r;
    low_votes_nxt  = e_low;
    high_votes_nxt = e_high;
    vote_cnt_nxt   = e_cnt;
    in_rec_nxt     = e_rec;
    rec_start_nxt  = rec_start_r;
    miss_rep_nxt   = e_miss_rep;
    miss_time_nxt  = e_miss_time;
    prio_nxt       = 1'b0;
    reason_nxt     = vtmd_pkg::REASON_NONE;

    if (!s1_r.qok) begin
      // trend cleared, window not remembered, missing timer kept
      hist_valid_nxt = 1'b0;
      low_votes_nxt  = '0;
      high_votes_nxt = '0;
      vote_cnt_nxt   = '0;
      in_rec_nxt     = 1'b0;
      prio_nxt       = 1'b1;
      reason_nxt     = vtmd_pkg::REASON_QUALITY;
    end else if (!cfg_ok) begin
      hist_valid_nxt = 1'b1;
      last_boot_nxt  = s1_r.boot;
      last_idx_nxt   = s1_r.idx;
      last_ts_nxt    = s1_r.ts;
      low_votes_nxt  = '0;
      high_votes_nxt = '0;
      vote_cnt_nxt   = '0;
      in_rec_nxt     = 1'b0;
      if (eligible) begin
        miss_rep_nxt  = 1'b1;
        miss_time_nxt = s1_r.ts;
        prio_nxt      = 1'b1;
      end
      reason_nxt = vtmd_pkg::REASON_BASELINE_MISS;
    end else begin
      hist_valid_nxt = 1'b1;
      last_boot_nxt  = s1_r.boot;
      last_idx_nxt   = s1_r.idx;
      last_ts_nxt    = s1_r.ts;
      miss_rep_nxt   = 1'b0;
      miss_time_nxt  = '0;
      if (sev) begin
        low_votes_nxt  = '0;
        high_votes_nxt = '0;
        vote_cnt_nxt   = '0;
        in_rec_nxt     = 1'b1;
        rec_start_nxt  = s1_r.ts;
        prio_nxt       = 1'b1;
        reason_nxt     = vtmd_pkg::REASON_SEVERE;
      end else begin
        low_votes_nxt  = low_add;
        high_votes_nxt = high_add;
        vote_cnt_nxt   = cnt_add;
        if (low_hits >= vtmd_pkg::VOTE_CNT_W'(vtmd_pkg::VOTE_NEED)) begin
          in_rec_nxt    = 1'b1;
          rec_start_nxt = s1_r.ts;
          prio_nxt      = 1'b1;
          reason_nxt    = vtmd_pkg::REASON_RMS_LOW;
        end else if (high_hits >= vtmd_pkg::VOTE_CNT_W'(vtmd_pkg::VOTE_NEED)) begin
          in_rec_nxt    = 1'b1;
          rec_start_nxt = s1_r.ts;
          prio_nxt      = 1'b1;
          reason_nxt    = vtmd_pkg::REASON_RMS_HIGH;
        end else if (held) begin
          prio_nxt   = 1'b1;
          reason_nxt = vtmd_pkg::REASON_RECOVERY_HOLD;
        end else begin
          in_rec_nxt = 1'b0;
          reason_nxt = s1_r.full ? vtmd_pkg::REASON_STORAGE : vtmd_pkg::REASON_NONE;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      hist_valid_r <= 1'b0;
      last_boot_r  <= '0;
      last_idx_r   <= '0;
      last_ts_r    <= '0;
      low_votes_r  <= '0;
      high_votes_r <= '0;
      vote_cnt_r   <= '0;
      in_rec_r     <= 1'b0;
      rec_start_r  <= '0;
      miss_rep_r   <= 1'b0;
      miss_time_r  <= '0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (s2_fire) begin
        hist_valid_r <= hist_valid_nxt;
        last_boot_r  <= last_boot_nxt;
        last_idx_r   <= last_idx_nxt;
        last_ts_r    <= last_ts_nxt;
        low_votes_r  <= low_votes_nxt;
        high_votes_r <= high_votes_nxt;
        vote_cnt_r   <= vote_cnt_nxt;
        in_rec_r     <= in_rec_nxt;
        rec_start_r  <= rec_start_nxt;
        miss_rep_r   <= miss_rep_nxt;
        miss_time_r  <= miss_time_nxt;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= s1_nxt;
    end
    if (s2_fire) begin
      prio_r   <= prio_nxt;
      reason_r <= reason_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_prio_reasons: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (reason_r == vtmd_pkg::REASON_SEVERE ||
                    reason_r == vtmd_pkg::REASON_QUALITY ||
                    reason_r == vtmd_pkg::REASON_RMS_LOW ||
                    reason_r == vtmd_pkg::REASON_RMS_HIGH ||
                    reason_r == vtmd_pkg::REASON_RECOVERY_HOLD) |-> prio_r)
    else $error("priority reason without priority mode");

  a_severe_recovery: assert property (@(posedge clk) disable iff (!rst_n)
    s2_fire && (reason_nxt == vtmd_pkg::REASON_SEVERE) |=>
      in_rec_r && (vote_cnt_r == '0) && (rec_start_r == $past(s1_r.ts)))
    else $error("severe window did not start recovery");

  a_quality_forgets: assert property (@(posedge clk) disable iff (!rst_n)
    s2_fire && !s1_r.qok |=> !hist_valid_r && !in_rec_r)
    else $error("bad quality window left history");

  a_empty_votes: assert property (@(posedge clk) disable iff (!rst_n)
    (vote_cnt_r == '0) |-> (low_votes_r == '0) && (high_votes_r == '0))
    else $error("votes held with empty vote window");
`endif

endmodule
